[rtl/core/chti_pkg.sv]
// Shared types, constants and the query microprogram of the cubic Hermite table interpolator.
// No dependencies; imported by every module of the block.
package chti_pkg;

    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = 7;
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int WIDE_W     = 40;
    localparam int MAG_W      = 38;
    localparam int SAT_W      = 48;
    localparam int DIVD_W     = MAG_W + FRAC_BITS;
    localparam int HALF_W     = MAG_W / 2;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int RF_DEPTH   = 16;
    localparam int RF_AW      = $clog2(RF_DEPTH);
    localparam int PROG_LEN   = 37;
    localparam int PC_W       = 6;

    localparam logic signed [WIDE_W-1:0] WIDE_MAX = WIDE_W'((64'sd1 <<< MAG_W) - 64'sd1);
    localparam logic signed [WIDE_W-1:0] ONE_Q    = WIDE_W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [WIDE_W-1:0] THREE_Q  = WIDE_W'(64'sd3 <<< FRAC_BITS);
    localparam logic signed [WIDE_W-1:0] HALF_Q   = WIDE_W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [DATA_W-1:0] NEG_ONE_Q = DATA_W'(-(64'sd1 <<< FRAC_BITS));

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_RSUB = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } alu_op_t;

    typedef enum logic [2:0] {
        B_REG   = 3'd0,
        B_ZERO  = 3'd1,
        B_ONE   = 3'd2,
        B_THREE = 3'd3,
        B_HALF  = 3'd4
    } bsel_t;

    typedef enum logic [1:0] {
        C_ALL  = 2'd0,
        C_FULL = 2'd1,
        C_LAST = 2'd2
    } cond_t;

    typedef struct packed {
        alu_op_t          op;
        logic [RF_AW-1:0] dst;
        logic [RF_AW-1:0] sa;
        logic [RF_AW-1:0] sb;
        bsel_t            bsel;
        cond_t            cond;
    } instr_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [WIDE_W-1:0] value;
    } alu_rsp_t;

    localparam logic [RF_AW-1:0] R_X0 = 4'd0;
    localparam logic [RF_AW-1:0] R_X1 = 4'd1;
    localparam logic [RF_AW-1:0] R_X2 = 4'd2;
    localparam logic [RF_AW-1:0] R_X3 = 4'd3;
    localparam logic [RF_AW-1:0] R_Y0 = 4'd4;
    localparam logic [RF_AW-1:0] R_Y1 = 4'd5;
    localparam logic [RF_AW-1:0] R_Y2 = 4'd6;
    localparam logic [RF_AW-1:0] R_Y3 = 4'd7;
    localparam logic [RF_AW-1:0] R_QX = 4'd8;
    localparam logic [RF_AW-1:0] R_T9  = 4'd9;
    localparam logic [RF_AW-1:0] R_T10 = 4'd10;
    localparam logic [RF_AW-1:0] R_T11 = 4'd11;
    localparam logic [RF_AW-1:0] R_T12 = 4'd12;
    localparam logic [RF_AW-1:0] R_T13 = 4'd13;
    localparam logic [RF_AW-1:0] R_T14 = 4'd14;
    localparam logic [RF_AW-1:0] R_T15 = 4'd15;

    function automatic logic signed [WIDE_W-1:0] sat_wide(input logic signed [SAT_W-1:0] v);
        logic signed [WIDE_W-1:0] r;
        if (v > SAT_W'(WIDE_MAX)) begin
            r = WIDE_MAX;
        end else if (v < -SAT_W'(WIDE_MAX)) begin
            r = -WIDE_MAX;
        end else begin
            r = v[WIDE_W-1:0];
        end
        return r;
    endfunction

    function automatic instr_t mk(input alu_op_t op, input logic [RF_AW-1:0] dst,
                                  input logic [RF_AW-1:0] sa, input logic [RF_AW-1:0] sb,
                                  input bsel_t bsel, input cond_t cond);
        instr_t r;
        r.op   = op;
        r.dst  = dst;
        r.sa   = sa;
        r.sb   = sb;
        r.bsel = bsel;
        r.cond = cond;
        return r;
    endfunction

    function automatic instr_t prog(input logic [PC_W-1:0] pc);
        instr_t r;
        case (pc)
            6'd0:  r = mk(OP_SUB,  R_T9,  R_X1,  R_X0,  B_REG,   C_ALL);
            6'd1:  r = mk(OP_SUB,  R_T10, R_Y1,  R_Y0,  B_REG,   C_ALL);
            6'd2:  r = mk(OP_DIV,  R_T9,  R_T10, R_T9,  B_REG,   C_ALL);
            6'd3:  r = mk(OP_SUB,  R_T10, R_X2,  R_X1,  B_REG,   C_ALL);
            6'd4:  r = mk(OP_SUB,  R_T11, R_Y2,  R_Y1,  B_REG,   C_ALL);
            6'd5:  r = mk(OP_DIV,  R_T11, R_T11, R_T10, B_REG,   C_ALL);
            6'd6:  r = mk(OP_ADD,  R_T12, R_T9,  R_T11, B_REG,   C_ALL);
            6'd7:  r = mk(OP_MUL,  R_T12, R_T12, R_T12, B_HALF,  C_ALL);
            6'd8:  r = mk(OP_MUL,  R_T12, R_T10, R_T12, B_REG,   C_ALL);
            6'd9:  r = mk(OP_SUB,  R_T13, R_X3,  R_X2,  B_REG,   C_FULL);
            6'd10: r = mk(OP_SUB,  R_T14, R_Y3,  R_Y2,  B_REG,   C_FULL);
            6'd11: r = mk(OP_DIV,  R_T13, R_T14, R_T13, B_REG,   C_FULL);
            6'd12: r = mk(OP_ADD,  R_T13, R_T11, R_T13, B_REG,   C_FULL);
            6'd13: r = mk(OP_MUL,  R_T13, R_T13, R_T13, B_HALF,  C_FULL);
            6'd14: r = mk(OP_ADD,  R_T13, R_T11, R_T11, B_ZERO,  C_LAST);
            6'd15: r = mk(OP_MUL,  R_T13, R_T10, R_T13, B_REG,   C_ALL);
            6'd16: r = mk(OP_SUB,  R_T14, R_QX,  R_X1,  B_REG,   C_ALL);
            6'd17: r = mk(OP_DIV,  R_T14, R_T14, R_T10, B_REG,   C_ALL);
            6'd18: r = mk(OP_RSUB, R_T15, R_T14, R_T14, B_ONE,   C_ALL);
            6'd19: r = mk(OP_ADD,  R_T9,  R_T14, R_T14, B_REG,   C_ALL);
            6'd20: r = mk(OP_MUL,  R_T11, R_T14, R_T14, B_REG,   C_ALL);
            6'd21: r = mk(OP_RSUB, R_X0,  R_T9,  R_T9,  B_THREE, C_ALL);
            6'd22: r = mk(OP_MUL,  R_X0,  R_T11, R_X0,  B_REG,   C_ALL);
            6'd23: r = mk(OP_MUL,  R_X0,  R_X0,  R_Y2,  B_REG,   C_ALL);
            6'd24: r = mk(OP_SUB,  R_X1,  R_T14, R_T14, B_ONE,   C_ALL);
            6'd25: r = mk(OP_MUL,  R_X1,  R_T11, R_X1,  B_REG,   C_ALL);
            6'd26: r = mk(OP_MUL,  R_X1,  R_X1,  R_T13, B_REG,   C_ALL);
            6'd27: r = mk(OP_ADD,  R_X0,  R_X0,  R_X1,  B_REG,   C_ALL);
            6'd28: r = mk(OP_ADD,  R_T9,  R_T9,  R_T9,  B_ONE,   C_ALL);
            6'd29: r = mk(OP_MUL,  R_T9,  R_T9,  R_T15, B_REG,   C_ALL);
            6'd30: r = mk(OP_MUL,  R_T9,  R_T9,  R_T15, B_REG,   C_ALL);
            6'd31: r = mk(OP_MUL,  R_T9,  R_T9,  R_Y1,  B_REG,   C_ALL);
            6'd32: r = mk(OP_MUL,  R_T14, R_T14, R_T15, B_REG,   C_ALL);
            6'd33: r = mk(OP_MUL,  R_T14, R_T14, R_T15, B_REG,   C_ALL);
            6'd34: r = mk(OP_MUL,  R_T14, R_T14, R_T12, B_REG,   C_ALL);
            6'd35: r = mk(OP_ADD,  R_T9,  R_T9,  R_T14, B_REG,   C_ALL);
            6'd36: r = mk(OP_ADD,  R_T9,  R_T9,  R_X0,  B_REG,   C_ALL);
            default: r = mk(OP_ADD, R_T9, R_T9,  R_T9,  B_REG,   C_ALL);
        endcase
        return r;
    endfunction

endpackage

[rtl/core/cubic_hermite_table_interpolator.sv]
// Cubic Hermite table interpolator: a load writes one table point; a query searches
// the segments in turn, then runs microcode (4 divides, 15 multiplies, the rest adds and
// subtracts) on the fixed-point unit with its bit-serial divider.
// One item is in work at a time; a finished result waits in the output register.
// aresetn is synchronous, active low; point_count resets to 64, tables are not cleared.
module cubic_hermite_table_interpolator import chti_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // point_index[5:0], x_value[37:6], y_value_in[69:38], zero
    input  logic        s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // y_result[31:0]
    output logic        m_tuser,   // out_of_range
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data   // point_count
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_SRD   = 8'b00000010,
        S_SCMP  = 8'b00000100,
        S_FETCH = 8'b00001000,
        S_RD    = 8'b00010000,
        S_GO    = 8'b00100000,
        S_WAIT  = 8'b01000000,
        S_DONE  = 8'b10000000
    } state_t;

    state_t                   state_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         i_reg;
    logic [3:0]               k_reg;
    logic [PC_W-1:0]          pc_reg;
    logic                     last_reg;
    logic signed [DATA_W-1:0] qx_reg;
    logic signed [DATA_W-1:0] res_reg;
    logic                     oor_reg;
    logic                     m_tvalid_reg;
    logic [DATA_W-1:0]        m_tdata_reg;
    logic                     m_tuser_reg;

    logic                     s_fire;
    logic [CNT_W-1:0]         n_used;
    logic                     tab_we;
    logic [ADDR_W-1:0]        tab_raddr;
    logic [CNT_W-1:0]         fetch_addr;
    logic signed [DATA_W-1:0] tab_rx;
    logic signed [DATA_W-1:0] tab_ry;
    instr_t                   ins;
    logic                     skip;
    logic                     rf_we;
    logic [RF_AW-1:0]         rf_waddr;
    logic signed [WIDE_W-1:0] rf_wdata;
    logic signed [WIDE_W-1:0] rf_qa;
    logic signed [WIDE_W-1:0] rf_qb;
    logic signed [WIDE_W-1:0] op_b;
    logic [3:0]               m_idx;
    alu_req_t                 alu_req;
    alu_rsp_t                 alu_rsp;
    logic signed [DATA_W-1:0] res_sat;
    logic                     out_free;

    assign s_fire    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign n_used    = (count_reg > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count_reg;

    assign tab_we     = s_fire && !s_tuser;
    assign fetch_addr = i_reg - 1'b1 + CNT_W'(k_reg[3:1]);
    assign tab_raddr  = (state_reg == S_SRD) ? ADDR_W'(i_reg + 1'b1) : fetch_addr[ADDR_W-1:0];

    chti_table u_table (
        .aclk  (aclk),
        .we    (tab_we),
        .waddr (s_tdata[ADDR_W-1:0]),
        .wx    (s_tdata[37:6]),
        .wy    (s_tdata[69:38]),
        .raddr (tab_raddr),
        .rx    (tab_rx),
        .ry    (tab_ry)
    );

    assign ins  = prog(pc_reg);
    assign skip = (ins.cond == C_FULL && last_reg) || (ins.cond == C_LAST && !last_reg);
    assign m_idx = k_reg - 1'b1;

    always_comb begin
        rf_we    = 1'b0;
        rf_waddr = ins.dst;
        rf_wdata = alu_rsp.value;
        if (state_reg == S_FETCH && k_reg != 4'd0) begin
            rf_we = 1'b1;
            if (m_idx == 4'd8) begin
                rf_waddr = R_QX;
                rf_wdata = WIDE_W'(qx_reg);
            end else if (m_idx[0]) begin
                rf_waddr = R_Y0 + RF_AW'(m_idx[2:1]);
                rf_wdata = WIDE_W'(tab_ry);
            end else begin
                rf_waddr = R_X0 + RF_AW'(m_idx[2:1]);
                rf_wdata = WIDE_W'(tab_rx);
            end
        end else if (state_reg == S_WAIT && alu_rsp.done) begin
            rf_we = 1'b1;
        end
    end

    chti_regfile u_regfile (
        .aclk  (aclk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .ra    (ins.sa),
        .rb    (ins.sb),
        .qa    (rf_qa),
        .qb    (rf_qb)
    );

    always_comb begin
        case (ins.bsel)
            B_ZERO:  op_b = '0;
            B_ONE:   op_b = ONE_Q;
            B_THREE: op_b = THREE_Q;
            B_HALF:  op_b = HALF_Q;
            default: op_b = rf_qb;
        endcase
    end

    assign alu_req.start = (state_reg == S_GO);
    assign alu_req.op    = ins.op;

    chti_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .a       (rf_qa),
        .b       (op_b),
        .rsp     (alu_rsp)
    );

    always_comb begin
        if (alu_rsp.value > WIDE_W'(32'sh7FFF_FFFF)) begin
            res_sat = 32'sh7FFF_FFFF;
        end else if (alu_rsp.value < -WIDE_W'(33'sh0_8000_0000)) begin
            res_sat = 32'sh8000_0000;
        end else begin
            res_sat = alu_rsp.value[DATA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= CNT_W'(MAX_POINTS);
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                count_reg <= cfg_data;
            end
            if (state_reg == S_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_fire && s_tuser) begin
                        state_reg <= S_SRD;
                    end
                end
                S_SRD: begin
                    if (i_reg + 1'b1 < n_used) begin
                        state_reg <= S_SCMP;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                S_SCMP: begin
                    if (qx_reg < tab_rx) begin
                        state_reg <= S_FETCH;
                    end else begin
                        state_reg <= S_SRD;
                    end
                end
                S_FETCH: begin
                    if (k_reg == 4'd9) begin
                        state_reg <= S_RD;
                    end
                end
                S_RD: begin
                    if (pc_reg == PC_W'(PROG_LEN)) begin
                        state_reg <= S_DONE;
                    end else if (!skip) begin
                        state_reg <= S_GO;
                    end
                end
                S_GO: begin
                    state_reg <= S_WAIT;
                end
                S_WAIT: begin
                    if (alu_rsp.done) begin
                        state_reg <= S_RD;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                qx_reg <= s_tdata[37:6];
                i_reg  <= CNT_W'(1);
            end
            S_SRD: begin
                res_reg <= NEG_ONE_Q;
                oor_reg <= 1'b1;
            end
            S_SCMP: begin
                last_reg <= (i_reg + CNT_W'(2) >= n_used);
                k_reg    <= '0;
                if (!(qx_reg < tab_rx)) begin
                    i_reg <= i_reg + 1'b1;
                end
            end
            S_FETCH: begin
                k_reg  <= k_reg + 1'b1;
                pc_reg <= '0;
            end
            S_RD: begin
                if (skip && pc_reg != PC_W'(PROG_LEN)) begin
                    pc_reg <= pc_reg + 1'b1;
                end
            end
            S_WAIT: begin
                if (alu_rsp.done) begin
                    pc_reg <= pc_reg + 1'b1;
                    if (pc_reg == PC_W'(PROG_LEN - 1)) begin
                        res_reg <= res_sat;
                        oor_reg <= 1'b0;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_tdata_reg <= res_reg;
                    m_tuser_reg <= oor_reg;
                end
            end
            default: begin
                k_reg <= k_reg;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[rtl/core/chti_table.sv]
// Breakpoint table: x and y memories, one write port, one registered read port.
// Depends on chti_pkg.
module chti_table import chti_pkg::*; (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [ADDR_W-1:0]        waddr,
    input  logic signed [DATA_W-1:0] wx,
    input  logic signed [DATA_W-1:0] wy,
    input  logic [ADDR_W-1:0]        raddr,
    output logic signed [DATA_W-1:0] rx,
    output logic signed [DATA_W-1:0] ry
);

    logic signed [DATA_W-1:0] x_mem [MAX_POINTS];
    logic signed [DATA_W-1:0] y_mem [MAX_POINTS];

    always_ff @(posedge aclk) begin
        if (we) begin
            x_mem[waddr] <= wx;
            y_mem[waddr] <= wy;
        end
        rx <= x_mem[raddr];
        ry <= y_mem[raddr];
    end

endmodule

[rtl/core/chti_regfile.sv]
// Working register file of the query sequencer: one write port, two registered read ports.
// Depends on chti_pkg.
module chti_regfile import chti_pkg::*; (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [RF_AW-1:0]         waddr,
    input  logic signed [WIDE_W-1:0] wdata,
    input  logic [RF_AW-1:0]         ra,
    input  logic [RF_AW-1:0]         rb,
    output logic signed [WIDE_W-1:0] qa,
    output logic signed [WIDE_W-1:0] qb
);

    logic signed [WIDE_W-1:0] mem [RF_DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        qa <= mem[ra];
        qb <= mem[rb];
    end

endmodule

[rtl/core/chti_alu.sv]
// Saturating fixed-point unit: add and subtract with a registered result, multiply in two partial
// products, divide one quotient bit per cycle. Depends on chti_pkg.
module chti_alu import chti_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  alu_req_t                 req,
    input  logic signed [WIDE_W-1:0] a,
    input  logic signed [WIDE_W-1:0] b,
    output alu_rsp_t                 rsp
);

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_MHI  = 4'b0010,
        A_MFIN = 4'b0100,
        A_DIV  = 4'b1000
    } alu_state_t;

    alu_state_t               state_reg;
    logic                     done_reg;
    logic signed [WIDE_W-1:0] val_reg;
    logic                     neg_reg;
    logic [MAG_W-1:0]         ua_reg;
    logic [MAG_W-1:0]         ub_reg;
    logic [PROD_W-1:0]        acc_reg;
    logic [MAG_W-1:0]         rem_reg;
    logic [DIVD_W-1:0]        quo_reg;
    logic [PC_W-1:0]          cnt_reg;

    logic signed [WIDE_W-1:0] abs_a;
    logic signed [WIDE_W-1:0] abs_b;
    logic signed [WIDE_W:0]   sum;
    logic [MAG_W:0]           trial;
    logic                     qbit;
    logic [MAG_W-1:0]         rem_next;
    logic [DIVD_W-1:0]        q_full;
    logic signed [PROD_W:0]   prod_s;
    logic signed [PROD_W:0]   prod_sh;

    assign abs_a = a[WIDE_W-1] ? -a : a;
    assign abs_b = b[WIDE_W-1] ? -b : b;

    always_comb begin
        case (req.op)
            OP_SUB:  sum = {a[WIDE_W-1], a} - {b[WIDE_W-1], b};
            OP_RSUB: sum = {b[WIDE_W-1], b} - {a[WIDE_W-1], a};
            default: sum = {a[WIDE_W-1], a} + {b[WIDE_W-1], b};
        endcase
    end

    assign trial    = {rem_reg, quo_reg[DIVD_W-1]};
    assign qbit     = (trial >= {1'b0, ub_reg});
    assign rem_next = qbit ? MAG_W'(trial - {1'b0, ub_reg}) : trial[MAG_W-1:0];
    assign q_full   = {quo_reg[DIVD_W-2:0], qbit};

    assign prod_s  = neg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});
    assign prod_sh = prod_s >>> FRAC_BITS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                A_IDLE: begin
                    if (req.start) begin
                        case (req.op)
                            OP_MUL: begin
                                state_reg <= A_MHI;
                            end
                            OP_DIV: begin
                                if (b == '0) begin
                                    done_reg <= 1'b1;
                                end else begin
                                    state_reg <= A_DIV;
                                end
                            end
                            default: begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                A_MHI: begin
                    state_reg <= A_MFIN;
                end
                A_MFIN: begin
                    state_reg <= A_IDLE;
                    done_reg  <= 1'b1;
                end
                A_DIV: begin
                    if (cnt_reg == PC_W'(DIVD_W - 1)) begin
                        state_reg <= A_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            A_IDLE: begin
                ua_reg  <= abs_a[MAG_W-1:0];
                ub_reg  <= abs_b[MAG_W-1:0];
                neg_reg <= a[WIDE_W-1] != b[WIDE_W-1];
                acc_reg <= PROD_W'(abs_a[HALF_W-1:0] * abs_b[MAG_W-1:0]);
                rem_reg <= '0;
                quo_reg <= {abs_a[MAG_W-1:0], FRAC_BITS'(0)};
                cnt_reg <= '0;
                if (req.op == OP_DIV) begin
                    val_reg <= '0;
                end else begin
                    val_reg <= sat_wide(SAT_W'(sum));
                end
            end
            A_MHI: begin
                acc_reg <= acc_reg
                         + (PROD_W'(ua_reg[MAG_W-1:HALF_W] * ub_reg) << HALF_W);
            end
            A_MFIN: begin
                if (acc_reg > (PROD_W'(1) << 62)) begin
                    val_reg <= neg_reg ? -WIDE_MAX : WIDE_MAX;
                end else begin
                    val_reg <= sat_wide(prod_sh[SAT_W-1:0]);
                end
            end
            A_DIV: begin
                rem_reg <= rem_next;
                quo_reg <= q_full;
                cnt_reg <= cnt_reg + 1'b1;
                if (q_full > DIVD_W'(WIDE_MAX)) begin
                    val_reg <= neg_reg ? -WIDE_MAX : WIDE_MAX;
                end else begin
                    val_reg <= neg_reg ? -$signed(WIDE_W'(q_full)) : $signed(WIDE_W'(q_full));
                end
            end
            default: begin
                val_reg <= val_reg;
            end
        endcase
    end

    assign rsp.done  = done_reg;
    assign rsp.value = val_reg;

endmodule

[rtl/core/chti_checker.sv]
// Port-level checks of the cubic Hermite table interpolator, bound to the top level.
// Depends on chti_pkg and cubic_hermite_table_interpolator.
module chti_checker import chti_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_oor_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == NEG_ONE_Q)
        else $error("out-of-range result is not -1.0");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("query transfer did not occupy the block");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("reset did not clear the channels");

endmodule

bind cubic_hermite_table_interpolator chti_checker u_chti_checker (.*);
